[hdl/eptpp_pkg.sv]
// Shared types, constants and helper functions for the endpoint transmit
// ping-pong manager. No dependencies; every other file of the block uses it.

package eptpp_pkg;

    // Default sizes of the block.
    localparam int MAX_ENDPOINTS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF   = 8;
    localparam int HANDLE_BITS_DEF   = 8;
    localparam int MAX_PACKET_DEF    = 64;

    // Fixed widths of the port fields.
    localparam int OPCODE_W   = 2;
    localparam int ENDPOINT_W = 4;
    localparam int HANDLE_W   = 8;
    localparam int LENGTH_W   = 7;
    localparam int KIND_W     = 3;
    localparam int ACTIVE_W   = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SUBMIT = 2'd0,
        OP_DONE   = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_ARMED   = 3'd0,
        KIND_QUEUED  = 3'd1,
        KIND_FREED   = 3'd2,
        KIND_FLUSHED = 3'd3,
        KIND_BAD_EP  = 3'd4,
        KIND_FULL    = 3'd5
    } t_kind;

    // Bank ownership mode of one endpoint.
    typedef enum logic [2:0] {
        MODE_BOTH_EVEN = 3'd0,
        MODE_BOTH_ODD  = 3'd1,
        MODE_EVEN_FREE = 3'd2,
        MODE_ODD_FREE  = 3'd3,
        MODE_NONE_EVEN = 3'd4,
        MODE_NONE_ODD  = 3'd5
    } t_mode;

    // One result word as it sits in the output register.
    typedef struct packed {
        t_kind                 kind;
        logic                  bank;
        logic [HANDLE_W-1:0]   handle;
        logic [LENGTH_W-1:0]   length;
        logic                  toggle;
        logic                  last;
    } t_result;

    // True when the given bank holds a packet in the given mode.
    function automatic logic bank_busy(t_mode mode, logic bank);
        logic busy;
        case (mode) inside
            MODE_NONE_EVEN, MODE_NONE_ODD: busy = 1'b1;
            MODE_EVEN_FREE:                busy = bank;
            MODE_ODD_FREE:                 busy = ~bank;
            default:                       busy = 1'b0;
        endcase
        return busy;
    endfunction

    // Mode after a free bank has been armed.
    function automatic t_mode mode_after_arm(t_mode mode);
        t_mode next;
        case (mode)
            MODE_BOTH_EVEN: next = MODE_ODD_FREE;
            MODE_BOTH_ODD:  next = MODE_EVEN_FREE;
            MODE_EVEN_FREE: next = MODE_NONE_ODD;
            MODE_ODD_FREE:  next = MODE_NONE_EVEN;
            default:        next = mode;
        endcase
        return next;
    endfunction

    // Mode after a bank finished and nothing waits to re-arm it.
    function automatic t_mode mode_after_done(t_mode mode, logic bank);
        t_mode next;
        case (mode)
            MODE_EVEN_FREE: next = MODE_BOTH_EVEN;
            MODE_ODD_FREE:  next = MODE_BOTH_ODD;
            default:        next = bank ? MODE_ODD_FREE : MODE_EVEN_FREE;
        endcase
        return next;
    endfunction

    // Mode after a flush: both free, keeping the bank order.
    function automatic t_mode mode_after_flush(t_mode mode);
        t_mode next;
        case (mode) inside
            MODE_EVEN_FREE, MODE_NONE_EVEN: next = MODE_BOTH_EVEN;
            MODE_ODD_FREE, MODE_NONE_ODD:   next = MODE_BOTH_ODD;
            default:                        next = mode;
        endcase
        return next;
    endfunction

endpackage

[hdl/eptpp_if.sv]
// Valid/ready channel interfaces of the endpoint transmit manager:
// command words in, result words out, and the configuration write channel.
// Depends on eptpp_pkg for the field widths.

interface eptpp_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [eptpp_pkg::OPCODE_W-1:0]     opcode;
    logic [eptpp_pkg::ENDPOINT_W-1:0]   endpoint;
    logic                               done_bank;
    logic [eptpp_pkg::HANDLE_W-1:0]     packet_handle;
    logic [eptpp_pkg::LENGTH_W-1:0]     packet_length;

    modport source (output valid, opcode, endpoint, done_bank, packet_handle,
                    packet_length, input ready);
    modport sink (input valid, opcode, endpoint, done_bank, packet_handle,
                  packet_length, output ready);
endinterface

interface eptpp_res_if;
    logic                               valid;
    logic                               ready;
    logic [eptpp_pkg::KIND_W-1:0]       kind;
    logic                               bank;
    logic [eptpp_pkg::HANDLE_W-1:0]     handle;
    logic [eptpp_pkg::LENGTH_W-1:0]     length;
    logic                               toggle;
    logic                               last;

    modport source (output valid, kind, bank, handle, length, toggle, last,
                    input ready);
    modport sink (input valid, kind, bank, handle, length, toggle, last,
                  output ready);
endinterface

interface eptpp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [eptpp_pkg::ACTIVE_W-1:0]     active_endpoints;

    modport source (output valid, active_endpoints, input ready);
    modport sink (input valid, active_endpoints, output ready);
endinterface

[hdl/eptpp_bufmem.sv]
// Buffer bookkeeping memories: the handle owned by each bank of each endpoint
// and the per-endpoint wait queues. Synchronous write, registered read.
// Depends on eptpp_pkg for default sizes.

module eptpp_bufmem #(
    parameter int MAX_ENDPOINTS = eptpp_pkg::MAX_ENDPOINTS_DEF,
    parameter int QUEUE_DEPTH   = eptpp_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS   = eptpp_pkg::HANDLE_BITS_DEF,
    parameter int LEN_BITS      = eptpp_pkg::LENGTH_W,
    localparam int EP_W         = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1,
    localparam int OA_W         = EP_W + 1,
    localparam int WDEPTH       = MAX_ENDPOINTS * QUEUE_DEPTH,
    localparam int WA_W         = (WDEPTH > 1) ? $clog2(WDEPTH) : 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_owner_we,
    input  logic [OA_W-1:0]                       i_owner_waddr,
    input  logic [HANDLE_BITS-1:0]                i_owner_wdata,
    input  logic [OA_W-1:0]                       i_owner_raddr,
    output logic [HANDLE_BITS-1:0]                o_owner_rdata,
    input  logic                                  i_wait_we,
    input  logic [WA_W-1:0]                       i_wait_waddr,
    input  logic [HANDLE_BITS-1:0]                i_wait_whandle,
    input  logic [LEN_BITS-1:0]                   i_wait_wlength,
    input  logic [WA_W-1:0]                       i_wait_raddr,
    output logic [HANDLE_BITS-1:0]                o_wait_rhandle,
    output logic [LEN_BITS-1:0]                   o_wait_rlength
);

    logic [HANDLE_BITS-1:0]              mem_owner [2*MAX_ENDPOINTS];
    logic [HANDLE_BITS+LEN_BITS-1:0]     mem_wait  [WDEPTH];

    // Bank owner store.
    always_ff @(posedge i_clk) begin
        if (i_owner_we) begin
            mem_owner[i_owner_waddr] <= i_owner_wdata;
        end
        o_owner_rdata <= mem_owner[i_owner_raddr];
    end

    // Wait queue store, handle and length side by side.
    always_ff @(posedge i_clk) begin
        if (i_wait_we) begin
            mem_wait[i_wait_waddr] <= {i_wait_whandle, i_wait_wlength};
        end
        {o_wait_rhandle, o_wait_rlength} <= mem_wait[i_wait_raddr];
    end

endmodule

[hdl/endpoint_tx_ping_pong_manager.sv]
// Endpoint transmit ping-pong manager: arms even/odd banks, queues and flushes.
// Depends on eptpp_pkg, the channel interfaces and eptpp_bufmem.
// One word at a time: a new command word is taken only when the sequencer is idle, and
// each result also waits for a free output register.
// Synchronous active-low reset: all endpoints both free even first, queues empty.

module endpoint_tx_ping_pong_manager #(
    parameter int MAX_ENDPOINTS = eptpp_pkg::MAX_ENDPOINTS_DEF,
    parameter int QUEUE_DEPTH   = eptpp_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS   = eptpp_pkg::HANDLE_BITS_DEF,
    parameter int MAX_PACKET    = eptpp_pkg::MAX_PACKET_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eptpp_cmd_if.sink   i_cmd,
    eptpp_res_if.source o_res,
    eptpp_cfg_if.sink   i_cfg
);

    localparam int EP_W   = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
    localparam int OA_W   = EP_W + 1;
    localparam int WDEPTH = MAX_ENDPOINTS * QUEUE_DEPTH;
    localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W  = $clog2(MAX_PACKET + 1);

    localparam logic [eptpp_pkg::ACTIVE_W-1:0] MaxEp     =
        eptpp_pkg::ACTIVE_W'(MAX_ENDPOINTS);
    localparam logic [eptpp_pkg::LENGTH_W-1:0] MaxLen    =
        eptpp_pkg::LENGTH_W'(MAX_PACKET);
    localparam logic [PTR_W-1:0]               LastPtr   = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]               FullCount = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DECODE = 13'b0000000000010,
        S_BAD    = 13'b0000000000100,
        S_SUBMIT = 13'b0000000001000,
        S_READ   = 13'b0000000010000,
        S_DFREE  = 13'b0000000100000,
        S_DARM   = 13'b0000001000000,
        S_FB0    = 13'b0000010000000,
        S_FW1    = 13'b0000100000000,
        S_FB1    = 13'b0001000000000,
        S_FQ     = 13'b0010000000000,
        S_FQW    = 13'b0100000000000,
        S_FEND   = 13'b1000000000000
    } t_state;

    // Control registers.
    t_state                             r_state, n_state;
    logic [eptpp_pkg::ACTIVE_W-1:0]     r_active;
    logic [EP_W-1:0]                    r_e, n_e;
    logic                               r_bsel, n_bsel;
    logic                               r_out_valid, n_out_valid;
    eptpp_pkg::t_result                 r_out, n_out;

    // Per-endpoint state.
    eptpp_pkg::t_mode                   r_mode  [MAX_ENDPOINTS];
    logic [PTR_W-1:0]                   r_head  [MAX_ENDPOINTS];
    logic [PTR_W-1:0]                   r_tail  [MAX_ENDPOINTS];
    logic [CNT_W-1:0]                   r_count [MAX_ENDPOINTS];
    logic                               ep_we;
    eptpp_pkg::t_mode                   n_ep_mode;
    logic [PTR_W-1:0]                   n_ep_head, n_ep_tail;
    logic [CNT_W-1:0]                   n_ep_count;

    // Latched command word.
    eptpp_pkg::t_opcode                 r_op;
    logic [eptpp_pkg::ENDPOINT_W-1:0]   r_ep;
    logic                               r_dbank;
    logic [HANDLE_BITS-1:0]             r_handle;
    logic [LEN_W-1:0]                   r_len;

    // Memory connections.
    logic                               owner_we;
    logic [OA_W-1:0]                    owner_waddr;
    logic [HANDLE_BITS-1:0]             owner_wdata;
    logic [HANDLE_BITS-1:0]             owner_rdata;
    logic                               wait_we;
    logic [WA_W-1:0]                    wait_waddr, wait_raddr;
    logic [HANDLE_BITS-1:0]             wait_rhandle;
    logic [LEN_W-1:0]                   wait_rlength;

    // Helpers.
    eptpp_pkg::t_mode                   cur_mode;
    logic [PTR_W-1:0]                   cur_head, cur_tail;
    logic [CNT_W-1:0]                   cur_count;
    logic                               cmd_accept;
    logic                               slot_free;
    logic [eptpp_pkg::ACTIVE_W-1:0]     limit;
    logic                               bad_ep;
    logic [eptpp_pkg::ENDPOINT_W-1:0]   ep_m1;
    logic [eptpp_pkg::LENGTH_W-1:0]     len_sat;
    logic                               sub_arm, sub_bank;
    eptpp_pkg::t_result                 res;

    assign cmd_accept = i_cmd.valid && i_cmd.ready;
    assign slot_free  = !r_out_valid || o_res.ready;

    assign cur_mode  = r_mode[r_e];
    assign cur_head  = r_head[r_e];
    assign cur_tail  = r_tail[r_e];
    assign cur_count = r_count[r_e];

    assign limit  = (r_active > MaxEp) ? MaxEp : r_active;
    assign bad_ep = (r_ep == '0) || (r_ep > limit);
    assign ep_m1  = r_ep - 1'b1;

    assign len_sat = (i_cmd.packet_length > MaxLen) ? MaxLen : i_cmd.packet_length;

    // Submit picks the even bank in the even-first and even-free modes, odd in the odd-first and odd-free.
    assign sub_arm  = (cur_mode == eptpp_pkg::MODE_BOTH_EVEN)
                   || (cur_mode == eptpp_pkg::MODE_EVEN_FREE)
                   || (cur_mode == eptpp_pkg::MODE_BOTH_ODD)
                   || (cur_mode == eptpp_pkg::MODE_ODD_FREE);
    assign sub_bank = (cur_mode == eptpp_pkg::MODE_BOTH_ODD)
                   || (cur_mode == eptpp_pkg::MODE_ODD_FREE);

    // Queue addresses: endpoint row plus pointer.
    assign wait_waddr  = WA_W'(int'(r_e) * QUEUE_DEPTH + int'(cur_tail));
    assign wait_raddr  = WA_W'(int'(r_e) * QUEUE_DEPTH + int'(cur_head));

    // Handshake outputs.
    assign i_cmd.ready   = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_res.valid   = r_out_valid;
    assign o_res.kind    = r_out.kind;
    assign o_res.bank    = r_out.bank;
    assign o_res.handle  = r_out.handle;
    assign o_res.length  = r_out.length;
    assign o_res.toggle  = r_out.toggle;
    assign o_res.last    = r_out.last;

    eptpp_bufmem #(
        .MAX_ENDPOINTS (MAX_ENDPOINTS),
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .HANDLE_BITS   (HANDLE_BITS),
        .LEN_BITS      (LEN_W)
    ) u_bufmem (
        .i_clk          (i_clk),
        .i_owner_we     (owner_we),
        .i_owner_waddr  (owner_waddr),
        .i_owner_wdata  (owner_wdata),
        .i_owner_raddr  ({r_e, r_bsel}),
        .o_owner_rdata  (owner_rdata),
        .i_wait_we      (wait_we),
        .i_wait_waddr   (wait_waddr),
        .i_wait_whandle (r_handle),
        .i_wait_wlength (r_len),
        .i_wait_raddr   (wait_raddr),
        .o_wait_rhandle (wait_rhandle),
        .o_wait_rlength (wait_rlength)
    );

    // Sequencer: walks one command word through its reads, writes and results.
    always_comb begin
        n_state     = r_state;
        n_e         = r_e;
        n_bsel      = r_bsel;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        ep_we       = 1'b0;
        n_ep_mode   = cur_mode;
        n_ep_head   = cur_head;
        n_ep_tail   = cur_tail;
        n_ep_count  = cur_count;
        owner_we    = 1'b0;
        owner_waddr = {r_e, r_bsel};
        owner_wdata = r_handle;
        wait_we     = 1'b0;
        res         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (cmd_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_e    = ep_m1[EP_W-1:0];
                n_bsel = (r_op == eptpp_pkg::OP_DONE) ? r_dbank : 1'b0;
                if (r_op == eptpp_pkg::OP_NONE) begin
                    n_state = S_IDLE;
                end else if (bad_ep) begin
                    n_state = S_BAD;
                end else if (r_op == eptpp_pkg::OP_SUBMIT) begin
                    n_state = S_SUBMIT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_BAD: begin
                if (slot_free) begin
                    res.kind    = eptpp_pkg::KIND_BAD_EP;
                    res.last    = 1'b1;
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_SUBMIT: begin
                if (slot_free) begin
                    res.handle = eptpp_pkg::HANDLE_W'(r_handle);
                    res.last   = 1'b1;
                    if (sub_arm) begin
                        owner_we    = 1'b1;
                        owner_waddr = {r_e, sub_bank};
                        ep_we       = 1'b1;
                        n_ep_mode   = eptpp_pkg::mode_after_arm(cur_mode);
                        res.kind    = eptpp_pkg::KIND_ARMED;
                        res.bank    = sub_bank;
                        res.length  = eptpp_pkg::LENGTH_W'(r_len);
                        res.toggle  = sub_bank;
                    end else if (cur_count == FullCount) begin
                        res.kind    = eptpp_pkg::KIND_FULL;
                    end else begin
                        wait_we     = 1'b1;
                        ep_we       = 1'b1;
                        n_ep_tail   = (cur_tail == LastPtr) ? '0 : cur_tail + 1'b1;
                        n_ep_count  = cur_count + 1'b1;
                        res.kind    = eptpp_pkg::KIND_QUEUED;
                    end
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_READ: begin
                // Memory read for the selected bank and queue head is in flight; S_DFREE and S_FB0 use its data.
                if (r_op == eptpp_pkg::OP_DONE) begin
                    n_state = eptpp_pkg::bank_busy(cur_mode, r_dbank) ? S_DFREE : S_IDLE;
                end else begin
                    n_state = S_FB0;
                end
            end
            S_DFREE: begin
                if (slot_free) begin
                    res.kind    = eptpp_pkg::KIND_FREED;
                    res.bank    = r_dbank;
                    res.handle  = eptpp_pkg::HANDLE_W'(owner_rdata);
                    res.last    = (cur_count == '0);
                    n_out       = res;
                    n_out_valid = 1'b1;
                    if (cur_count != '0) begin
                        n_state = S_DARM;
                    end else begin
                        ep_we     = 1'b1;
                        n_ep_mode = eptpp_pkg::mode_after_done(cur_mode, r_dbank);
                        n_state   = S_IDLE;
                    end
                end
            end
            S_DARM: begin
                if (slot_free) begin
                    owner_we    = 1'b1;
                    owner_waddr = {r_e, r_dbank};
                    owner_wdata = wait_rhandle;
                    ep_we       = 1'b1;
                    n_ep_head   = (cur_head == LastPtr) ? '0 : cur_head + 1'b1;
                    n_ep_count  = cur_count - 1'b1;
                    n_ep_mode   = eptpp_pkg::mode_after_arm(cur_mode);
                    res.kind    = eptpp_pkg::KIND_ARMED;
                    res.bank    = r_dbank;
                    res.handle  = eptpp_pkg::HANDLE_W'(wait_rhandle);
                    res.length  = eptpp_pkg::LENGTH_W'(wait_rlength);
                    res.toggle  = r_dbank;
                    res.last    = 1'b1;
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_FB0: begin
                if (!eptpp_pkg::bank_busy(cur_mode, 1'b0)) begin
                    n_bsel  = 1'b1;
                    n_state = S_FW1;
                end else if (slot_free) begin
                    res.kind    = eptpp_pkg::KIND_FREED;
                    res.handle  = eptpp_pkg::HANDLE_W'(owner_rdata);
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_bsel      = 1'b1;
                    n_state     = S_FW1;
                end
            end
            S_FW1: begin
                // Odd bank owner read in flight.
                n_state = S_FB1;
            end
            S_FB1: begin
                if (!eptpp_pkg::bank_busy(cur_mode, 1'b1)) begin
                    n_state = S_FQ;
                end else if (slot_free) begin
                    res.kind    = eptpp_pkg::KIND_FREED;
                    res.bank    = 1'b1;
                    res.handle  = eptpp_pkg::HANDLE_W'(owner_rdata);
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_state     = S_FQ;
                end
            end
            S_FQ: begin
                if (cur_count == '0) begin
                    n_state = S_FEND;
                end else if (slot_free) begin
                    ep_we       = 1'b1;
                    n_ep_head   = (cur_head == LastPtr) ? '0 : cur_head + 1'b1;
                    n_ep_count  = cur_count - 1'b1;
                    res.kind    = eptpp_pkg::KIND_FREED;
                    res.handle  = eptpp_pkg::HANDLE_W'(wait_rhandle);
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_state     = S_FQW;
                end
            end
            S_FQW: begin
                // Next queue entry read in flight.
                n_state = S_FQ;
            end
            S_FEND: begin
                if (slot_free) begin
                    ep_we       = 1'b1;
                    n_ep_head   = '0;
                    n_ep_tail   = '0;
                    n_ep_mode   = eptpp_pkg::mode_after_flush(cur_mode);
                    res.kind    = eptpp_pkg::KIND_FLUSHED;
                    res.last    = 1'b1;
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_e         <= '0;
            r_bsel      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_e         <= n_e;
            r_bsel      <= n_bsel;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_active <= i_cfg.active_endpoints;
            end
        end
    end

    // Per-endpoint mode and queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENDPOINTS; i++) begin
                r_mode[i]  <= eptpp_pkg::MODE_BOTH_EVEN;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (ep_we) begin
            r_mode[r_e]  <= n_ep_mode;
            r_head[r_e]  <= n_ep_head;
            r_tail[r_e]  <= n_ep_tail;
            r_count[r_e] <= n_ep_count;
        end
    end

    // Command word capture and output register payload.
    always_ff @(posedge i_clk) begin
        if (cmd_accept) begin
            r_op     <= eptpp_pkg::t_opcode'(i_cmd.opcode);
            r_ep     <= i_cmd.endpoint;
            r_dbank  <= i_cmd.done_bank;
            r_handle <= HANDLE_BITS'(i_cmd.packet_handle);
            r_len    <= LEN_W'(len_sat);
        end
        r_out <= n_out;
    end

endmodule

[hdl/eptpp_checker.sv]
// Port-level checks for the endpoint transmit manager, bound to the top level.
// Depends on eptpp_pkg and endpoint_tx_ping_pong_manager.

module eptpp_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_cmd_valid,
    input logic                                 i_cmd_ready,
    input logic                                 i_res_valid,
    input logic                                 i_res_ready,
    input logic [eptpp_pkg::KIND_W-1:0]         i_res_kind,
    input logic                                 i_res_bank,
    input logic [eptpp_pkg::HANDLE_W-1:0]       i_res_handle,
    input logic [eptpp_pkg::LENGTH_W-1:0]       i_res_length,
    input logic                                 i_res_toggle,
    input logic                                 i_res_last
);

    // A stalled result word holds until taken.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
            && $stable({i_res_kind, i_res_bank, i_res_handle, i_res_length,
                        i_res_toggle, i_res_last}))
        else $error("result word changed while stalled");

    // The sequencer is busy in the cycle after it takes a command.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command accepted on two consecutive cycles");

    // An armed bank always carries the data toggle of its own bank.
    a_armed_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_kind == eptpp_pkg::KIND_ARMED
            |-> i_res_toggle == i_res_bank)
        else $error("armed toggle differs from bank");

    // Only an armed result carries a length or a toggle.
    a_unarmed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_kind != eptpp_pkg::KIND_ARMED
            |-> i_res_length == '0 && !i_res_toggle)
        else $error("length or toggle on a result that arms nothing");

    // Queued, full, bad endpoint and flush complete always end a command.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_kind == eptpp_pkg::KIND_QUEUED
            || i_res_kind == eptpp_pkg::KIND_FULL
            || i_res_kind == eptpp_pkg::KIND_BAD_EP
            || i_res_kind == eptpp_pkg::KIND_FLUSHED) |-> i_res_last)
        else $error("terminal result word without last");

endmodule

bind endpoint_tx_ping_pong_manager eptpp_checker u_eptpp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_kind   (o_res.kind),
    .i_res_bank   (o_res.bank),
    .i_res_handle (o_res.handle),
    .i_res_length (o_res.length),
    .i_res_toggle (o_res.toggle),
    .i_res_last   (o_res.last)
);
